// ===== rtl/core/bmls_pkg.sv =====
package bmls_pkg;

  // target buttons that count in the mask
  localparam int unsigned TARGETS = 16;
  localparam logic [15:0] LIVE_LIM =
    (TARGETS >= 16) ? 16'hFFFF : 16'((32'd1 << TARGETS) - 32'd1);

  // default depth of the record table
  localparam int unsigned REC_DEPTH_DEF = 16;

  // reset values of the configuration registers
  localparam logic [15:0] TIMEOUT_RST = 16'd10000;
  localparam logic [15:0] SHOW_RST    = 16'd6000;

  // floor(ms / 1000) as a reciprocal multiply, exact for 16-bit ms
  localparam logic [16:0] DIGIT_MUL   = 17'd67109;
  localparam int unsigned DIGIT_SHIFT = 26;

  // request codes
  typedef logic [1:0] func_t;
  localparam func_t FUNC_TICK  = 2'd0;
  localparam func_t FUNC_EVENT = 2'd1;
  localparam func_t FUNC_START = 2'd2;
  localparam func_t FUNC_STOP  = 2'd3;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_TARGET_MASK = 2'd0;
  localparam cfg_idx_t CFG_TIMEOUT_MS  = 2'd1;
  localparam cfg_idx_t CFG_SHOW_MS     = 2'd2;

  // learn stages as they appear on the result channel
  typedef enum logic [2:0] {
    STG_IDLE       = 3'd0,
    STG_FAULT      = 3'd1,
    STG_PRESS      = 3'd2,
    STG_HOLD       = 3'd3,
    STG_AGAIN      = 3'd4,
    STG_AGAIN_HOLD = 3'd5,
    STG_COMPLETE   = 3'd6
  } stage_e;

  // result sequencing
  typedef enum logic [1:0] {
    SEQ_IN,
    SEQ_DRAIN,
    SEQ_STATUS
  } seq_e;

  typedef struct packed {
    func_t       func;
    logic [15:0] elapsed_ms;
    logic [15:0] device_id;
    logic        any_device;
    logic [15:0] button_code;
    logic [7:0]  part;
    logic        pressed;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic        last;
    logic [2:0]  stage;
    logic [3:0]  target_index;
    logic [15:0] device_out;
    logic        device_known;
    logic        countdown_shown;
    logic [6:0]  countdown_digit;
    logic [15:0] rec_source_button;
    logic [7:0]  rec_source_part;
    logic [3:0]  rec_target_index;
    logic [4:0]  record_count;
  } out_item_t;

  typedef struct packed {
    cfg_idx_t    index;
    logic [15:0] value;
  } cfg_item_t;

  // one entry of the record table
  typedef struct packed {
    logic [15:0] button;
    logic [7:0]  part;
    logic [3:0]  target;
  } rec_t;

  // lowest set bit: {found, index}
  function automatic logic [4:0] lowest_set(input logic [15:0] m);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 15; i >= 0; i--) begin
      if (m[i]) begin
        r = {1'b1, 4'(i)};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/bmls_if.sv =====
interface bmls_in_if import bmls_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bmls_out_if import bmls_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bmls_cfg_if import bmls_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/button_mapping_learn_sequencer.sv =====
// Learn-mode sequencer for remapping controller buttons. A start request arms
// it on the lowest set bit of target_mask; each target then needs press,
// release, press, release of the same source button and part, and every
// confirmed pair is stored in a record table (RECORDS entries, one write and
// one read port, contents undefined until written). Tick requests count the
// timeout down and skip the target on expiry. Every request is taken in the
// input state and its status result is loaded once the result register is
// free. A request that completes the sequence first streams out the N stored
// records, read from the registered table port one entry per cycle while the
// result register is not stalled, then its status. The result register
// frees the request side as soon as the last result is loaded, while that
// result still waits for its transfer. Configuration writes are always taken.
module button_mapping_learn_sequencer import bmls_pkg::*; #(
  parameter int unsigned RECORDS = REC_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bmls_in_if.sink     in_i,
  bmls_out_if.source  out_o,
  bmls_cfg_if.sink    cfg_i
);

  localparam int unsigned AW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
  localparam int unsigned CW = $clog2(RECORDS + 1);

  // configuration registers
  logic [15:0] mask_q, timeout_q, show_q;

  // sequencer state
  stage_e      stage_q, stage_d;
  logic [3:0]  target_q, target_d;
  logic [15:0] dev_q, dev_d;
  logic        chosen_q, chosen_d;
  logic [15:0] cap_btn_q, cap_btn_d;
  logic [7:0]  cap_part_q, cap_part_d;
  logic [15:0] rem_q, rem_d;
  logic [CW-1:0] total_q, total_d;

  // result sequencing
  seq_e        seq_q, seq_d;
  logic [CW-1:0] idx_q, idx_d;
  logic        rdv_q;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  // record table
  rec_t        mem_q [RECORDS];
  rec_t        rdata_q;
  logic        mem_we;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] rd_next;

  logic        in_fire, slot_free, in_ready;
  logic        load_rec, load_stat, done;
  logic        rec_last;
  logic [15:0] live_mask, above_mask;
  logic [16:0] above_base;
  logic [4:0]  nxt_sel, first_sel;
  logic        active, shown;
  logic [32:0] digit_prod;
  out_item_t   stat;

  assign in_fire   = in_i.valid && in_ready;
  assign slot_free = !out_valid_q || out_o.ready;
  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= '0;
      timeout_q <= TIMEOUT_RST;
      show_q    <= SHOW_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        CFG_TARGET_MASK: mask_q    <= cfg_i.data.value;
        CFG_TIMEOUT_MS:  timeout_q <= cfg_i.data.value;
        CFG_SHOW_MS:     show_q    <= cfg_i.data.value;
        default: ;
      endcase
    end
  end

  // target search: next set mask bit above the current one, and the first
  assign live_mask  = mask_q & LIVE_LIM;
  assign above_base = (17'd2 << target_q) - 17'd1;
  assign above_mask = live_mask & ~above_base[15:0];
  assign nxt_sel    = lowest_set(above_mask);
  assign first_sel  = lowest_set(live_mask);

  // request processing
  always_comb begin
    logic same, pr, do_adv;
    stage_d    = stage_q;
    target_d   = target_q;
    dev_d      = dev_q;
    chosen_d   = chosen_q;
    cap_btn_d  = cap_btn_q;
    cap_part_d = cap_part_q;
    rem_d      = rem_q;
    total_d    = total_q;
    mem_we     = 1'b0;
    do_adv     = 1'b0;
    done       = 1'b0;
    pr   = in_i.data.pressed;
    same = (in_i.data.button_code == cap_btn_q) && (in_i.data.part == cap_part_q);
    if (in_fire) begin
      case (in_i.data.func)
        FUNC_TICK: begin
          if (stage_q != STG_IDLE && stage_q != STG_COMPLETE) begin
            if (rem_q <= in_i.data.elapsed_ms) begin
              do_adv = 1'b1;
            end else begin
              rem_d = rem_q - in_i.data.elapsed_ms;
            end
          end
        end
        FUNC_EVENT: begin
          // an unchosen device ignores releases entirely
          if (stage_q != STG_IDLE && (chosen_q || pr)) begin
            if (!chosen_q) begin
              dev_d    = in_i.data.device_id;
              chosen_d = 1'b1;
            end
            case (stage_q)
              STG_FAULT, STG_PRESS: begin
                if (pr) begin
                  cap_btn_d  = in_i.data.button_code;
                  cap_part_d = in_i.data.part;
                  stage_d    = STG_HOLD;
                  rem_d      = timeout_q;
                end
              end
              STG_HOLD: begin
                stage_d = (pr || !same) ? STG_FAULT : STG_AGAIN;
                rem_d   = timeout_q;
              end
              STG_AGAIN: begin
                if (pr) begin
                  stage_d = same ? STG_AGAIN_HOLD : STG_FAULT;
                  rem_d   = timeout_q;
                end
              end
              STG_AGAIN_HOLD: begin
                // fault from here keeps the running timeout
                if (pr || !same) begin
                  stage_d = STG_FAULT;
                end else begin
                  if (total_q < CW'(RECORDS)) begin
                    mem_we  = 1'b1;
                    total_d = total_q + CW'(1);
                  end
                  do_adv = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        FUNC_START: begin
          dev_d    = in_i.data.any_device ? 16'd0 : in_i.data.device_id;
          chosen_d = !in_i.data.any_device;
          rem_d    = timeout_q;
          if (!first_sel[4]) begin
            stage_d = STG_IDLE;
          end else begin
            target_d = first_sel[3:0];
            stage_d  = STG_PRESS;
            total_d  = '0;
          end
        end
        FUNC_STOP: begin
          stage_d = STG_IDLE;
        end
        default: ;
      endcase
      // move to the next set mask bit, or finish
      if (do_adv) begin
        rem_d = timeout_q;
        if (nxt_sel[4]) begin
          target_d = nxt_sel[3:0];
          stage_d  = STG_PRESS;
        end else begin
          stage_d = STG_COMPLETE;
          done    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q    <= STG_IDLE;
      target_q   <= '0;
      dev_q      <= '0;
      chosen_q   <= 1'b0;
      cap_btn_q  <= '0;
      cap_part_q <= '0;
      rem_q      <= '0;
      total_q    <= '0;
    end else begin
      stage_q    <= stage_d;
      target_q   <= target_d;
      dev_q      <= dev_d;
      chosen_q   <= chosen_d;
      cap_btn_q  <= cap_btn_d;
      cap_part_q <= cap_part_d;
      rem_q      <= rem_d;
      total_q    <= total_d;
    end
  end

  // record table, one write and one registered read
  assign rd_next = load_rec ? idx_q + CW'(1) : idx_q;
  assign rd_addr = rd_next[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[total_q[AW-1:0]] <= '{button: cap_btn_q, part: cap_part_q, target: target_q};
    end
    rdata_q <= mem_q[rd_addr];
  end

  // sequencer next state
  assign rec_last = (idx_q + CW'(1)) == total_q;

  always_comb begin
    seq_d = seq_q;
    idx_d = idx_q;
    case (seq_q)
      SEQ_IN: begin
        if (in_fire) begin
          idx_d = '0;
          seq_d = (done && total_d != '0) ? SEQ_DRAIN : SEQ_STATUS;
        end
      end
      SEQ_DRAIN: begin
        if (load_rec) begin
          idx_d = idx_q + CW'(1);
          if (rec_last) begin
            seq_d = SEQ_STATUS;
          end
        end
      end
      SEQ_STATUS: begin
        if (load_stat) begin
          seq_d = SEQ_IN;
        end
      end
      default: seq_d = SEQ_IN;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    load_rec  = 1'b0;
    load_stat = 1'b0;
    case (seq_q)
      SEQ_IN:     in_ready  = 1'b1;
      SEQ_DRAIN:  load_rec  = rdv_q && slot_free;
      SEQ_STATUS: load_stat = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SEQ_IN;
      idx_q <= '0;
      rdv_q <= 1'b0;
    end else begin
      seq_q <= seq_d;
      idx_q <= idx_d;
      rdv_q <= (seq_q == SEQ_DRAIN);
    end
  end

  // status fields shared by every result
  assign active     = (stage_q != STG_IDLE) && (stage_q != STG_COMPLETE);
  assign shown      = active && (rem_q < show_q);
  assign digit_prod = 33'(rem_q) * 33'(DIGIT_MUL);

  always_comb begin
    stat = '0;
    stat.stage           = stage_q;
    stat.target_index    = target_q;
    stat.device_out      = dev_q;
    stat.device_known    = chosen_q;
    stat.countdown_shown = shown;
    stat.countdown_digit = shown ? digit_prod[DIGIT_SHIFT +: 7] : 7'd0;
    stat.record_count    = 5'(total_q);
  end

  // result register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (load_rec) begin
      out_d                   = stat;
      out_d.kind              = 1'b1;
      out_d.rec_source_button = rdata_q.button;
      out_d.rec_source_part   = rdata_q.part;
      out_d.rec_target_index  = rdata_q.target;
      out_valid_d             = 1'b1;
    end else if (load_stat) begin
      out_d       = stat;
      out_d.last  = 1'b1;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // checks
  a_drain_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q == SEQ_DRAIN |-> idx_q < total_q)
    else $error("record drain index beyond stored count");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> total_q < CW'(RECORDS))
    else $error("record table write with full table");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> seq_q != SEQ_IN)
    else $error("accepted request produced no result");

  a_record_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind |-> !out_q.last && out_q.record_count != 5'd0)
    else $error("record result marked last or with empty table");

endmodule
